>>> sv/qmpo_pkg.sv
// qmpo_pkg: shared types and constants of the quad motor pwm output gate
// used by the lane, merge and top level modules; no dependencies

package qmpo_pkg;

  localparam int TS_W     = 48;
  localparam int THR_W    = 16;
  localparam int PULSE_W  = 12;
  localparam int PERIOD_W = 16;
  localparam int IDLE_W   = 13;
  localparam int UPD_W    = 32;
  localparam int REG_W    = 16;
  localparam int IDX_W    = 2;
  localparam int MOTORS   = 4;
  localparam int Q_FRAC   = 12;

  // full throttle in q3.12
  localparam logic [IDLE_W-1:0] Q_ONE = 13'd4096;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MIN_PULSE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_MAX_PULSE   = 2'd1;
  localparam logic [IDX_W-1:0] REG_WRITE_PER   = 2'd2;
  localparam logic [IDX_W-1:0] REG_IDLE_THRESH = 2'd3;

  // register reset values
  localparam logic [PULSE_W-1:0]  MIN_PULSE_RST   = 12'd1000;
  localparam logic [PULSE_W-1:0]  MAX_PULSE_RST   = 12'd2000;
  localparam logic [PERIOD_W-1:0] WRITE_PER_RST   = 16'd5000;
  localparam logic [IDLE_W-1:0]   IDLE_THRESH_RST = 13'd205;

  // settings every lane sees
  typedef struct packed {
    logic [PULSE_W-1:0] min_pulse;
    logic [PULSE_W-1:0] span;
  } lane_ctl_t;

  // settings the merge stage sees
  typedef struct packed {
    logic               armed;
    logic [IDLE_W-1:0]  idle_threshold;
    logic [PULSE_W-1:0] min_pulse;
  } merge_ctl_t;

endpackage

>>> sv/qmpo_ifs.sv
// qmpo_ctl_if and qmpo_pwm_if: valid/ready channels of the output gate
// widths come from qmpo_pkg

interface qmpo_ctl_if;
  logic                              valid;
  logic                              ready;
  logic [qmpo_pkg::TS_W-1:0]         timestamp_us;
  logic                              armed;
  logic signed [qmpo_pkg::THR_W-1:0] throttle_front_left;
  logic signed [qmpo_pkg::THR_W-1:0] throttle_front_right;
  logic signed [qmpo_pkg::THR_W-1:0] throttle_rear_left;
  logic signed [qmpo_pkg::THR_W-1:0] throttle_rear_right;

  modport source (
    output valid, timestamp_us, armed, throttle_front_left, throttle_front_right,
           throttle_rear_left, throttle_rear_right,
    input  ready
  );
  modport sink (
    input  valid, timestamp_us, armed, throttle_front_left, throttle_front_right,
           throttle_rear_left, throttle_rear_right,
    output ready
  );
endinterface

interface qmpo_pwm_if;
  logic                          valid;
  logic                          ready;
  logic [qmpo_pkg::PULSE_W-1:0]  pulse_front_left;
  logic [qmpo_pkg::PULSE_W-1:0]  pulse_front_right;
  logic [qmpo_pkg::PULSE_W-1:0]  pulse_rear_left;
  logic [qmpo_pkg::PULSE_W-1:0]  pulse_rear_right;
  logic                          should_write;
  logic [qmpo_pkg::UPD_W-1:0]    update_time_us;

  modport source (
    output valid, pulse_front_left, pulse_front_right, pulse_rear_left,
           pulse_rear_right, should_write, update_time_us,
    input  ready
  );
  modport sink (
    input  valid, pulse_front_left, pulse_front_right, pulse_rear_left,
           pulse_rear_right, should_write, update_time_us,
    output ready
  );
endinterface

>>> sv/qmpo_lane.sv
// qmpo_lane: pulse width of one motor from its throttle
// clamps to 0..1.0 and scales into min..max; uses qmpo_pkg

module qmpo_lane (
  input  logic signed [qmpo_pkg::THR_W-1:0]   throttle,
  input  qmpo_pkg::lane_ctl_t                 ctl,
  output logic        [qmpo_pkg::PULSE_W-1:0] pulse
);

  logic [qmpo_pkg::IDLE_W-1:0]                    clamped;
  logic [qmpo_pkg::IDLE_W+qmpo_pkg::PULSE_W-1:0]  prod;
  logic [qmpo_pkg::IDLE_W-1:0]                    scaled;
  logic [qmpo_pkg::IDLE_W-1:0]                    sum;

  always_comb begin
    if (throttle < 0) begin
      clamped = '0;
    end else if (throttle > $signed({3'b000, qmpo_pkg::Q_ONE})) begin
      clamped = qmpo_pkg::Q_ONE;
    end else begin
      clamped = throttle[qmpo_pkg::IDLE_W-1:0];
    end
  end

  assign prod   = {{qmpo_pkg::PULSE_W{1'b0}}, clamped} *
                  {{qmpo_pkg::IDLE_W{1'b0}}, ctl.span};
  assign scaled = prod[qmpo_pkg::IDLE_W+qmpo_pkg::PULSE_W-1:qmpo_pkg::Q_FRAC];
  assign sum    = {1'b0, ctl.min_pulse} + scaled;
  assign pulse  = sum[qmpo_pkg::PULSE_W-1:0];

endmodule

>>> sv/qmpo_merge.sv
// qmpo_merge: finds the largest throttle and forces idle when disarmed or low
// combines the four lane pulses; uses qmpo_pkg

module qmpo_merge (
  input  logic signed [qmpo_pkg::MOTORS-1:0][qmpo_pkg::THR_W-1:0]   throttle,
  input  logic        [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0] lane_pulse,
  input  qmpo_pkg::merge_ctl_t                                      ctl,
  output logic        [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0] pulse
);

  logic signed [qmpo_pkg::THR_W-1:0] top_front;
  logic signed [qmpo_pkg::THR_W-1:0] top_rear;
  logic signed [qmpo_pkg::THR_W-1:0] top;
  logic                              force_idle;

  // two-level max tree
  assign top_front = ($signed(throttle[1]) > $signed(throttle[0])) ? throttle[1] : throttle[0];
  assign top_rear  = ($signed(throttle[3]) > $signed(throttle[2])) ? throttle[3] : throttle[2];
  assign top       = ($signed(top_rear) > $signed(top_front)) ? top_rear : top_front;

  assign force_idle = !ctl.armed ||
                      ($signed({top[qmpo_pkg::THR_W-1], top}) <=
                       $signed({4'b0000, ctl.idle_threshold}));

  always_comb begin
    for (int i = 0; i < qmpo_pkg::MOTORS; i++) begin
      pulse[i] = force_idle ? ctl.min_pulse : lane_pulse[i];
    end
  end

endmodule

>>> sv/quad_motor_pwm_output_gate.sv
// quad_motor_pwm_output_gate: write gating, held state and output stage
// depends on qmpo_pkg, qmpo_ifs, qmpo_lane and qmpo_merge
//
//  channel | dir | handshake     | payload
//  ctl     | in  | valid/ready   | timestamp_us, armed, four throttles (q3.12)
//  pwm     | out | valid/ready   | four pulse widths, should_write, update_time_us
//  wr_*    | in  | wr_en only    | wr_index, wr_data
//
// one item per cycle while ctl.ready is high; an item's result is registered and shows on pwm
// the next cycle unless pwm stalls; the due check and the held pulses are settled within the
// accepting cycle, so the next item sees them at once; four lanes scale the throttles side by side
// a skid register takes one result while pwm stalls; ctl.ready drops while it is full
// rst is synchronous; it restores the register defaults and clears the held state

module quad_motor_pwm_output_gate (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [qmpo_pkg::IDX_W-1:0]      wr_index,
  input  logic [qmpo_pkg::REG_W-1:0]      wr_data,
  qmpo_ctl_if.sink                        ctl,
  qmpo_pwm_if.source                      pwm
);

  localparam int RES_W = qmpo_pkg::MOTORS * qmpo_pkg::PULSE_W + 1 + qmpo_pkg::UPD_W;

  // configuration
  logic [qmpo_pkg::PULSE_W-1:0]  min_pulse_us;
  logic [qmpo_pkg::PULSE_W-1:0]  max_pulse_us;
  logic [qmpo_pkg::PERIOD_W-1:0] write_period_us;
  logic [qmpo_pkg::IDLE_W-1:0]   idle_threshold;

  // held state
  logic [qmpo_pkg::TS_W-1:0]                             last_write_time;
  logic [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0]    held_pulse;
  logic [qmpo_pkg::UPD_W-1:0]                            held_update_time;

  logic                                                  accept;
  logic                                                  due;
  logic [qmpo_pkg::TS_W-1:0]                             elapsed;
  logic [qmpo_pkg::PULSE_W-1:0]                          span;
  qmpo_pkg::lane_ctl_t                                   lane_ctl;
  qmpo_pkg::merge_ctl_t                                  merge_ctl;
  logic signed [qmpo_pkg::MOTORS-1:0][qmpo_pkg::THR_W-1:0] throttle;
  logic [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0]    lane_pulse;
  logic [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0]    new_pulse;
  logic [qmpo_pkg::MOTORS-1:0][qmpo_pkg::PULSE_W-1:0]    held_pulse_next;
  logic [qmpo_pkg::UPD_W-1:0]                            held_update_time_next;
  logic [RES_W-1:0]                                      result;

  // output stage
  logic             out_valid;
  logic [RES_W-1:0] out_data;
  logic             skid_valid;
  logic [RES_W-1:0] skid_data;
  logic             out_fire;

  assign ctl.ready = !skid_valid;
  assign accept    = ctl.valid && ctl.ready;
  assign out_fire  = out_valid && pwm.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pulse_us    <= qmpo_pkg::MIN_PULSE_RST;
      max_pulse_us    <= qmpo_pkg::MAX_PULSE_RST;
      write_period_us <= qmpo_pkg::WRITE_PER_RST;
      idle_threshold  <= qmpo_pkg::IDLE_THRESH_RST;
    end else if (wr_en) begin
      case (wr_index)
        qmpo_pkg::REG_MIN_PULSE:   min_pulse_us    <= wr_data[qmpo_pkg::PULSE_W-1:0];
        qmpo_pkg::REG_MAX_PULSE:   max_pulse_us    <= wr_data[qmpo_pkg::PULSE_W-1:0];
        qmpo_pkg::REG_WRITE_PER:   write_period_us <= wr_data[qmpo_pkg::PERIOD_W-1:0];
        qmpo_pkg::REG_IDLE_THRESH: idle_threshold  <= wr_data[qmpo_pkg::IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  // write gating
  assign elapsed = ctl.timestamp_us - last_write_time;
  assign due = (last_write_time == '0) ||
               ((ctl.timestamp_us >= last_write_time) &&
                (elapsed >= {{(qmpo_pkg::TS_W-qmpo_pkg::PERIOD_W){1'b0}}, write_period_us}));

  assign span = (max_pulse_us >= min_pulse_us) ? (max_pulse_us - min_pulse_us) : '0;

  assign lane_ctl.min_pulse = min_pulse_us;
  assign lane_ctl.span      = span;

  assign merge_ctl.armed          = ctl.armed;
  assign merge_ctl.idle_threshold = idle_threshold;
  assign merge_ctl.min_pulse      = min_pulse_us;

  assign throttle[0] = ctl.throttle_front_left;
  assign throttle[1] = ctl.throttle_front_right;
  assign throttle[2] = ctl.throttle_rear_left;
  assign throttle[3] = ctl.throttle_rear_right;

  for (genvar g = 0; g < qmpo_pkg::MOTORS; g++) begin : g_lane
    qmpo_lane u_lane (
      .throttle (throttle[g]),
      .ctl      (lane_ctl),
      .pulse    (lane_pulse[g])
    );
  end

  qmpo_merge u_merge (
    .throttle   (throttle),
    .lane_pulse (lane_pulse),
    .ctl        (merge_ctl),
    .pulse      (new_pulse)
  );

  assign held_pulse_next       = due ? new_pulse : held_pulse;
  assign held_update_time_next = due ? ctl.timestamp_us[qmpo_pkg::UPD_W-1:0] : held_update_time;

  assign result = {held_pulse_next[0], held_pulse_next[1], held_pulse_next[2],
                   held_pulse_next[3], due, held_update_time_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_write_time  <= '0;
      held_pulse       <= '0;
      held_update_time <= '0;
    end else if (accept && due) begin
      last_write_time  <= ctl.timestamp_us;
      held_pulse       <= held_pulse_next;
      held_update_time <= held_update_time_next;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || out_fire) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          out_valid  <= accept;
        end
      end else if (accept) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_fire) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= result;
      end
    end else if (accept) begin
      skid_data <= result;
    end
  end

  assign pwm.valid             = out_valid;
  assign pwm.pulse_front_left  = out_data[RES_W-1 -: qmpo_pkg::PULSE_W];
  assign pwm.pulse_front_right = out_data[RES_W-1-qmpo_pkg::PULSE_W -: qmpo_pkg::PULSE_W];
  assign pwm.pulse_rear_left   = out_data[RES_W-1-2*qmpo_pkg::PULSE_W -: qmpo_pkg::PULSE_W];
  assign pwm.pulse_rear_right  = out_data[RES_W-1-3*qmpo_pkg::PULSE_W -: qmpo_pkg::PULSE_W];
  assign pwm.should_write      = out_data[qmpo_pkg::UPD_W];
  assign pwm.update_time_us    = out_data[qmpo_pkg::UPD_W-1:0];

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output item in front");

  a_write_stores_time: assert property (@(posedge clk) disable iff (rst)
    (accept && due) |=> (last_write_time == $past(ctl.timestamp_us)) &&
                        (held_update_time == $past(ctl.timestamp_us[qmpo_pkg::UPD_W-1:0])))
    else $error("due write did not store its timestamp");

  a_hold_when_not_due: assert property (@(posedge clk) disable iff (rst)
    (accept && !due) |=> $stable(held_pulse) && $stable(last_write_time))
    else $error("held state changed on an item that was not due");
`endif

endmodule

>>> verif/quad_motor_pwm_output_gate_test.sv
// quad_motor_pwm_output_gate_test: self-checking bench for the quad motor pwm output gate
// drives ctl and the register port, predicts every pwm item and compares it field by field
// depends on qmpo_pkg, qmpo_ifs and quad_motor_pwm_output_gate

module quad_motor_pwm_output_gate_test;
  timeunit 1ns;
  timeprecision 1ps;
  import qmpo_pkg::*;

  localparam int CLK_HALF    = 4;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT    = 18;
  localparam int PHASE_ITEMS = 170;
  localparam int RAND_PHASES = 8;

  // motor order in the packed arrays: 0 front left, 1 front right, 2 rear left, 3 rear right
  typedef struct packed {
    logic [TS_W-1:0]                  ts;
    logic                             armed;
    logic [MOTORS-1:0][THR_W-1:0]     thr;
  } ctl_item_t;

  typedef struct packed {
    logic [MOTORS-1:0][PULSE_W-1:0]   pulse;
    logic                             should_write;
    logic [UPD_W-1:0]                 update_time;
  } pwm_item_t;

  logic               clk;
  logic               rst;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_index;
  logic [REG_W-1:0]   wr_data;

  qmpo_ctl_if ctl_ch ();
  qmpo_pwm_if pwm_ch ();

  quad_motor_pwm_output_gate dut (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .ctl      (ctl_ch),
    .pwm      (pwm_ch)
  );

  // settings and held state as the gate should see them
  logic [PULSE_W-1:0]             set_min;
  logic [PULSE_W-1:0]             set_max;
  logic [PERIOD_W-1:0]            set_period;
  logic [IDLE_W-1:0]              set_idle;
  logic [TS_W-1:0]                last_write_ts;
  logic [MOTORS-1:0][PULSE_W-1:0] held_pulse;
  logic [UPD_W-1:0]               held_update;

  ctl_item_t pending_cmds [$];
  pwm_item_t predicted_pwm [$];
  ctl_item_t on_wire;

  int mismatches;
  int items_queued;
  int results_seen;
  int writes_seen;
  int settings_loaded;
  int phase_no;
  logic hold_sink;
  logic steady;
  logic [TS_W-1:0] clock_now;

  string pulse_name [MOTORS] = '{"pulse_front_left", "pulse_front_right",
                                 "pulse_rear_left", "pulse_rear_right"};

  function automatic logic [PULSE_W-1:0] throttle_to_pulse(logic signed [THR_W-1:0] thr,
                                                           logic [PULSE_W-1:0] span);
    logic [IDLE_W-1:0] t;
    logic [24:0]       prod;
    if (thr < 0) t = '0;
    else if (int'(thr) > int'(Q_ONE)) t = Q_ONE;
    else t = thr[IDLE_W-1:0];
    prod = 25'(t) * 25'(span);
    return set_min + PULSE_W'(prod >> Q_FRAC);
  endfunction

  function automatic pwm_item_t gate_predict(ctl_item_t c);
    pwm_item_t          r;
    logic               due;
    int                 top;
    logic [PULSE_W-1:0] span;
    due = (last_write_ts == '0) ||
          (c.ts >= last_write_ts && (c.ts - last_write_ts) >= TS_W'(set_period));
    if (due) begin
      span = (set_max >= set_min) ? set_max - set_min : '0;
      top = int'($signed(c.thr[0]));
      for (int i = 1; i < MOTORS; i++)
        if (int'($signed(c.thr[i])) > top) top = int'($signed(c.thr[i]));
      for (int i = 0; i < MOTORS; i++)
        held_pulse[i] = (!c.armed || top <= int'(set_idle)) ? set_min
                        : throttle_to_pulse(c.thr[i], span);
      last_write_ts = c.ts;
      held_update = c.ts[UPD_W-1:0];
    end
    r.pulse = held_pulse;
    r.should_write = due;
    r.update_time = held_update;
    return r;
  endfunction

  task automatic flag_field(string field, logic [TS_W-1:0] want, logic [TS_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("mismatch in %s of pwm item %0d: expected %0d, got %0d",
                 field, results_seen, want, got);
    end
  endtask

  task automatic queue_item(logic [TS_W-1:0] ts, logic armed,
                            logic [THR_W-1:0] fl, logic [THR_W-1:0] fr,
                            logic [THR_W-1:0] rl, logic [THR_W-1:0] rr);
    ctl_item_t c;
    c.ts = ts;
    c.armed = armed;
    c.thr[0] = fl;
    c.thr[1] = fr;
    c.thr[2] = rl;
    c.thr[3] = rr;
    pending_cmds.push_back(c);
    items_queued++;
  endtask

  // writes all four registers back to back, only while the gate is idle
  task automatic load_settings(int min_us, int max_us, int period_us, int idle_q);
    @(posedge clk);
    wr_en <= 1'b1;
    wr_index <= REG_MIN_PULSE;
    wr_data <= REG_W'(min_us);
    @(posedge clk);
    wr_index <= REG_MAX_PULSE;
    wr_data <= REG_W'(max_us);
    @(posedge clk);
    wr_index <= REG_WRITE_PER;
    wr_data <= REG_W'(period_us);
    @(posedge clk);
    wr_index <= REG_IDLE_THRESH;
    wr_data <= REG_W'(idle_q);
    @(posedge clk);
    wr_en <= 1'b0;
    set_min = PULSE_W'(min_us);
    set_max = PULSE_W'(max_us);
    set_period = PERIOD_W'(period_us);
    set_idle = IDLE_W'(idle_q);
    settings_loaded++;
  endtask

  task automatic drain;
    while (pending_cmds.size() != 0 || ctl_ch.valid !== 1'b0 || predicted_pwm.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_reg(int lo, int hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return int'($urandom_range(lo, hi));
    endcase
  endfunction

  function automatic logic [THR_W-1:0] pick_throttle();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(5))
          0: return 16'h8000;
          1: return 16'h7fff;
          2: return 16'd0;
          3: return 16'd4096;
          4: return 16'd4097;
          default: return 16'hffff;
        endcase
      end
      1, 2: return THR_W'($urandom);
      default: return THR_W'(int'($urandom_range(0, 4400)) - 200);
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ctl driver: accepted items go through the predictor, the next one comes off the queue
  always @(posedge clk) begin : drive_ctl
    if (!rst) begin
      if (ctl_ch.valid && ctl_ch.ready) predicted_pwm.push_back(gate_predict(on_wire));
      if (!ctl_ch.valid || ctl_ch.ready) begin
        if (pending_cmds.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          on_wire = pending_cmds.pop_front();
          ctl_ch.valid <= 1'b1;
          ctl_ch.timestamp_us <= on_wire.ts;
          ctl_ch.armed <= on_wire.armed;
          ctl_ch.throttle_front_left <= on_wire.thr[0];
          ctl_ch.throttle_front_right <= on_wire.thr[1];
          ctl_ch.throttle_rear_left <= on_wire.thr[2];
          ctl_ch.throttle_rear_right <= on_wire.thr[3];
        end else begin
          ctl_ch.valid <= 1'b0;
        end
      end
    end
  end

  // pwm monitor and ready generator
  always @(posedge clk) begin : watch_pwm
    pwm_item_t got;
    pwm_item_t want;
    if (!rst && pwm_ch.valid === 1'b1 && pwm_ch.ready) begin
      got.pulse[0] = pwm_ch.pulse_front_left;
      got.pulse[1] = pwm_ch.pulse_front_right;
      got.pulse[2] = pwm_ch.pulse_rear_left;
      got.pulse[3] = pwm_ch.pulse_rear_right;
      got.should_write = pwm_ch.should_write;
      got.update_time = pwm_ch.update_time_us;
      results_seen++;
      if (predicted_pwm.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("pwm item %0d arrived with nothing predicted", results_seen);
      end else begin
        want = predicted_pwm.pop_front();
        for (int i = 0; i < MOTORS; i++)
          flag_field(pulse_name[i], TS_W'(want.pulse[i]), TS_W'(got.pulse[i]));
        flag_field("should_write", TS_W'(want.should_write), TS_W'(got.should_write));
        flag_field("update_time_us", TS_W'(want.update_time), TS_W'(got.update_time));
        if (got.should_write === 1'b1) writes_seen++;
      end
    end
    pwm_ch.ready <= !rst && !hold_sink && (steady || $urandom_range(99) >= IDLE_PCT);
  end

  // long sink stall in one phase so the skid register fills and ctl.ready drops
  initial begin : squeeze_sink
    hold_sink = 1'b0;
    wait (phase_no == 3);
    repeat (10) @(posedge clk);
    hold_sink <= 1'b1;
    repeat (150) @(posedge clk);
    hold_sink <= 1'b0;
  end

  initial begin : run_limit
    #(200_000 * 2 * CLK_HALF);
    $display("timed out with %0d items still predicted", predicted_pwm.size());
    $display("quad_motor_pwm_output_gate_test NOT OK");
    $finish;
  end

  initial begin : stimulus
    logic [TS_W-1:0]              ts;
    logic [TS_W-1:0]              leap;
    logic [MOTORS-1:0][THR_W-1:0] thr;
    logic                         quiet;
    int                           r;

    rst = 1'b1;
    steady = 1'b0;
    phase_no = -1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    ctl_ch.valid = 1'b0;
    ctl_ch.timestamp_us = '0;
    ctl_ch.armed = 1'b0;
    ctl_ch.throttle_front_left = '0;
    ctl_ch.throttle_front_right = '0;
    ctl_ch.throttle_rear_left = '0;
    ctl_ch.throttle_rear_right = '0;
    pwm_ch.ready = 1'b0;
    set_min = MIN_PULSE_RST;
    set_max = MAX_PULSE_RST;
    set_period = WRITE_PER_RST;
    set_idle = IDLE_THRESH_RST;
    last_write_ts = '0;
    held_pulse = '0;
    held_update = '0;
    mismatches = 0;
    items_queued = 0;
    results_seen = 0;
    writes_seen = 0;
    settings_loaded = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: first write, write at time zero, period edges, clamping, idle edges
    queue_item(48'd0, 1'b1, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'd0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
    queue_item(48'd100, 1'b1, 16'd2048, 16'd1024, 16'd4095, 16'd1);
    queue_item(48'd5099, 1'b1, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'd5100, 1'b1, 16'd3000, 16'd2000, 16'd1000, 16'd500);
    queue_item(48'd50, 1'b1, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'd10100, 1'b1, 16'h8000, 16'h7fff, 16'd4097, 16'd0);
    queue_item(48'd15100, 1'b0, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'd20100, 1'b1, 16'd205, 16'hffff, 16'd100, 16'd0);
    queue_item(48'd25100, 1'b1, 16'd206, 16'd1, 16'd4095, 16'h8000);
    queue_item(48'd30100, 1'b1, 16'h5555, 16'haaaa, 16'd206, -16'sd200);
    drain;

    // full span, zero period, zero idle threshold
    load_settings(0, 4095, 0, 0);
    queue_item(48'd30100, 1'b1, 16'd4096, 16'd1, 16'd2048, -16'sd5);
    queue_item(48'd30100, 1'b1, 16'd0, 16'd0, 16'hffff, 16'h8000);
    queue_item(48'd30101, 1'b1, 16'd1, 16'd0, 16'd0, 16'd0);
    drain;

    // max below min, longest period, threshold at full throttle
    load_settings(4095, 0, 65535, 4096);
    queue_item(48'd95635, 1'b1, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'd95636, 1'b1, 16'd4097, 16'd4097, 16'd4097, 16'd4097);
    queue_item(48'd161170, 1'b1, 16'd4097, 16'd0, 16'd0, 16'd0);
    drain;
    clock_now = 48'd161170;

    for (int p = 0; p < RAND_PHASES; p++) begin
      phase_no = p;
      if (p == 0)
        load_settings(MIN_PULSE_RST, MAX_PULSE_RST, WRITE_PER_RST, IDLE_THRESH_RST);
      else if (p % 2 == 1)
        load_settings($urandom_range(900, 1100), $urandom_range(1800, 2100),
                      $urandom_range(0, 8000), $urandom_range(0, 600));
      else
        load_settings(pick_reg(0, 4095), pick_reg(0, 4095), pick_reg(0, 65535),
                      pick_reg(0, 4096));
      steady <= (p == 5);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          // forward jump so the upper timestamp bits move without getting stuck
          leap = TS_W'({$urandom, $urandom});
          clock_now += leap & 48'h01ff_ffff_ffff;
          ts = clock_now;
        end else if (r < 10) begin
          ts = clock_now - TS_W'($urandom_range(1, 3000));
        end else begin
          clock_now += TS_W'($urandom_range(0, 2 * int'(set_period) + 8));
          ts = clock_now;
        end
        quiet = ($urandom_range(99) < 12);
        for (int m = 0; m < MOTORS; m++)
          thr[m] = quiet ? THR_W'(int'($urandom_range(0, int'(set_idle) + 300)) - 300)
                         : pick_throttle();
        queue_item(ts, $urandom_range(99) < 85, thr[0], thr[1], thr[2], thr[3]);
      end
      drain;
      steady <= 1'b0;
    end

    // top of the timestamp range, then items behind it
    phase_no = RAND_PHASES;
    load_settings(1000, 2000, 0, 205);
    queue_item(48'hffff_ffff_ffff, 1'b1, 16'd4096, 16'd2048, 16'd1024, 16'd0);
    queue_item(48'hffff_ffff_ffff, 1'b1, 16'h5555, 16'haaaa, 16'd3000, 16'd300);
    queue_item(48'd0, 1'b1, 16'd4096, 16'd4096, 16'd4096, 16'd4096);
    queue_item(48'h8000_0000_0000, 1'b1, 16'd1000, 16'd1000, 16'd1000, 16'd1000);
    drain;

    repeat (8) @(posedge clk);
    if (predicted_pwm.size() != 0) begin
      $display("%0d predicted pwm items never arrived", predicted_pwm.size());
      mismatches += predicted_pwm.size();
    end
    $display("sent %0d ctl items across %0d register settings", items_queued, settings_loaded);
    $display("checked %0d pwm items: %0d fresh writes, %0d held repeats, %0d mismatches",
             results_seen, writes_seen, results_seen - writes_seen, mismatches);
    if (mismatches == 0)
      $display("quad_motor_pwm_output_gate_test OK");
    else
      $display("quad_motor_pwm_output_gate_test NOT OK");
    $finish;
  end

endmodule
